>>> src/max_pool_2x2_with_argmax_assert.svh
// assertion macros used by the port-level checker file
`ifndef MAX_POOL_2X2_WITH_ARGMAX_ASSERT_SVH
`define MAX_POOL_2X2_WITH_ARGMAX_ASSERT_SVH

// same-cycle implication, off while reset is low
`define MP2_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// next-cycle implication, off while reset is low
`define MP2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

>>> src/mp2_pkg.sv
// shared constants and types of the 2x2 max pooling block
package mp2_pkg;

    // sizes
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_PLANES  = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int PAIR_SLOTS  = MAX_WIDTH / 2;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int PLANE_BITS = $clog2(MAX_PLANES);
    localparam int SLOT_BITS  = $clog2(PAIR_SLOTS);

    // configuration port
    localparam int CFG_DIM_BITS   = 11;
    localparam int CFG_PLANE_BITS = 17;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 17;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_TOTAL  = 2'd2;

    localparam logic [CFG_DIM_BITS-1:0]   WIDTH_RESET  = CFG_DIM_BITS'(1024);
    localparam logic [CFG_DIM_BITS-1:0]   HEIGHT_RESET = CFG_DIM_BITS'(1024);
    localparam logic [CFG_PLANE_BITS-1:0] TOTAL_RESET  = CFG_PLANE_BITS'(1);

    // winning position codes
    localparam logic [1:0] POS_TL = 2'd0;
    localparam logic [1:0] POS_TR = 2'd1;
    localparam logic [1:0] POS_BL = 2'd2;
    localparam logic [1:0] POS_BR = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // where a sample sits in its window, from the raster scan
    typedef struct packed {
        logic                 in_range;
        logic                 right;
        logic                 bottom;
        logic                 pend;
        logic                 fend;
        logic [SLOT_BITS-1:0] slot;
    } t_tag;

    // line buffer entry: top-row pair maximum and its column
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   col;
    } t_pair;

endpackage

>>> src/mp2_scan.sv
// raster position counters and window tagging of each incoming sample
module mp2_scan
    import mp2_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic [CFG_DIM_BITS-1:0]   i_plane_width,
    input  logic [CFG_DIM_BITS-1:0]   i_plane_height,
    input  logic [CFG_PLANE_BITS-1:0] i_plane_total,
    output t_tag                      o_tag
);

    localparam logic [CFG_DIM_BITS-1:0]   DIM_MIN   = CFG_DIM_BITS'(2);
    localparam logic [CFG_DIM_BITS-1:0]   W_MAX     = CFG_DIM_BITS'(MAX_WIDTH);
    localparam logic [CFG_DIM_BITS-1:0]   H_MAX     = CFG_DIM_BITS'(MAX_HEIGHT);
    localparam logic [CFG_PLANE_BITS-1:0] N_MIN     = CFG_PLANE_BITS'(1);
    localparam logic [CFG_PLANE_BITS-1:0] N_MAX     = CFG_PLANE_BITS'(MAX_PLANES);
    localparam logic [CFG_DIM_BITS-1:0]   DIM_ONE   = CFG_DIM_BITS'(1);
    localparam logic [CFG_PLANE_BITS-1:0] PLANE_ONE = CFG_PLANE_BITS'(1);

    logic [COL_BITS-1:0]       r_col,   n_col;
    logic [ROW_BITS-1:0]       r_row,   n_row;
    logic [PLANE_BITS-1:0]     r_plane, n_plane;

    logic [CFG_DIM_BITS-1:0]   w, h, w_used, h_used;
    logic [CFG_PLANE_BITS-1:0] n;
    logic [CFG_DIM_BITS-1:0]   col_ext, row_ext, col_inc, row_inc;
    logic [CFG_PLANE_BITS-1:0] plane_ext, plane_inc;
    logic                      pend;

    // clamp the configured sizes to their legal ranges
    always_comb begin
        w = (i_plane_width < DIM_MIN) ? DIM_MIN :
            (i_plane_width > W_MAX) ? W_MAX : i_plane_width;
        h = (i_plane_height < DIM_MIN) ? DIM_MIN :
            (i_plane_height > H_MAX) ? H_MAX : i_plane_height;
        n = (i_plane_total < N_MIN) ? N_MIN :
            (i_plane_total > N_MAX) ? N_MAX : i_plane_total;
        w_used = {w[CFG_DIM_BITS-1:1], 1'b0};
        h_used = {h[CFG_DIM_BITS-1:1], 1'b0};
    end

    assign col_ext   = CFG_DIM_BITS'(r_col);
    assign row_ext   = CFG_DIM_BITS'(r_row);
    assign plane_ext = CFG_PLANE_BITS'(r_plane);
    assign col_inc   = col_ext + DIM_ONE;
    assign row_inc   = row_ext + DIM_ONE;
    assign plane_inc = plane_ext + PLANE_ONE;

    // tag of the sample at the current position
    assign pend = (row_ext == h_used - DIM_ONE) && (col_ext == w_used - DIM_ONE);
    always_comb begin
        o_tag.in_range = (col_ext < w_used) && (row_ext < h_used);
        o_tag.right    = r_col[0];
        o_tag.bottom   = r_row[0];
        o_tag.pend     = pend;
        o_tag.fend     = pend && (plane_ext == n - PLANE_ONE);
        o_tag.slot     = r_col[COL_BITS-1:1];
    end

    // advance column, row and plane, wrapping at or past each bound
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_plane = r_plane;
        if (i_advance) begin
            n_col = col_inc[COL_BITS-1:0];
            if (col_inc >= w) begin
                n_col = '0;
                n_row = row_inc[ROW_BITS-1:0];
                if (row_inc >= h) begin
                    n_row   = '0;
                    n_plane = plane_inc[PLANE_BITS-1:0];
                    if (plane_inc >= n) begin
                        n_plane = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
        end
    end

endmodule

>>> src/max_pool_2x2_with_argmax.sv
// Top level of the 2x2 stride-2 max pooling block with winning position.
// One sample is taken per clock unless stalled; a result is registered
// when a bottom-right sample fires and holds until the consumer takes it,
// while other samples keep flowing. The input register feeds one stage of
// compare logic and a result register; the line buffer of top-row pair
// maxima is a 512 x 17 bit memory with one write and one registered read
// per cycle, and it needs no clearing pass after reset. Configuration
// writes are always ready and must be made while no sample is in flight.
module max_pool_2x2_with_argmax
    import mp2_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample input
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    // pooled output
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_pooled_value,
    output logic [1:0]                o_winner_pos,
    output logic                      o_plane_end,
    output logic                      o_frame_end,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic [1:0]             pos;
    } t_held;

    logic [CFG_DIM_BITS-1:0]   r_plane_width;
    logic [CFG_DIM_BITS-1:0]   r_plane_height;
    logic [CFG_PLANE_BITS-1:0] r_plane_total;

    t_tag    scan_tag;
    logic    accept;

    logic    r_s1_valid;
    t_sample r_s1_sample;
    t_tag    r_s1_tag;
    logic    s1_tl, s1_tr, s1_bl, s1_br, s1_fire;

    t_pair   r_mem [PAIR_SLOTS];
    t_pair   r_rd;
    t_pair   n_pair;
    logic    bypass;

    t_sample r_held_left;
    t_held   r_held_pair, n_held_pair, n_result;

    logic    r_out_valid;
    t_held   r_out;
    logic    r_out_pend, r_out_fend;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_width  <= WIDTH_RESET;
            r_plane_height <= HEIGHT_RESET;
            r_plane_total  <= TOTAL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PLANE_WIDTH:  r_plane_width  <= i_cfg_data[CFG_DIM_BITS-1:0];
                CFG_PLANE_HEIGHT: r_plane_height <= i_cfg_data[CFG_DIM_BITS-1:0];
                CFG_PLANE_TOTAL:  r_plane_total  <= i_cfg_data[CFG_PLANE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // raster scan
    mp2_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (accept),
        .i_plane_width  (r_plane_width),
        .i_plane_height (r_plane_height),
        .i_plane_total  (r_plane_total),
        .o_tag          (scan_tag)
    );

    // window position of the registered sample
    assign s1_tl = r_s1_valid && r_s1_tag.in_range && !r_s1_tag.bottom && !r_s1_tag.right;
    assign s1_tr = r_s1_valid && r_s1_tag.in_range && !r_s1_tag.bottom &&  r_s1_tag.right;
    assign s1_bl = r_s1_valid && r_s1_tag.in_range &&  r_s1_tag.bottom && !r_s1_tag.right;
    assign s1_br = r_s1_valid && r_s1_tag.in_range &&  r_s1_tag.bottom &&  r_s1_tag.right;

    // only a bottom-right sample can wait, and only on a full stalled output
    assign s1_fire = r_s1_valid && (!s1_br || !r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_fire;
    assign accept  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= i_sample_value;
            r_s1_tag    <= scan_tag;
        end
    end

    // top-row pair maximum, earlier column wins a tie
    always_comb begin
        if ($signed(r_s1_sample) > $signed(r_held_left)) begin
            n_pair = '{value: r_s1_sample, col: 1'b1};
        end else begin
            n_pair = '{value: r_held_left, col: 1'b0};
        end
    end

    // line buffer: write on top-right, read for the incoming sample,
    // forwarding a write to the same slot in the same cycle
    assign bypass = s1_fire && s1_tr && (r_s1_tag.slot == scan_tag.slot);

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_tr) begin
            r_mem[r_s1_tag.slot] <= n_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (bypass) begin
                r_rd <= n_pair;
            end else begin
                r_rd <= r_mem[scan_tag.slot];
            end
        end
    end

    // running maximum after the bottom-left sample
    always_comb begin
        if ($signed(r_s1_sample) > $signed(r_rd.value)) begin
            n_held_pair = '{value: r_s1_sample, pos: POS_BL};
        end else begin
            n_held_pair = '{value: r_rd.value, pos: r_rd.col ? POS_TR : POS_TL};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_left <= '0;
            r_held_pair <= '0;
        end else begin
            if (s1_fire && s1_tl) begin
                r_held_left <= r_s1_sample;
            end
            if (s1_fire && s1_bl) begin
                r_held_pair <= n_held_pair;
            end
        end
    end

    // final compare on the bottom-right sample
    always_comb begin
        if ($signed(r_s1_sample) > $signed(r_held_pair.value)) begin
            n_result = '{value: r_s1_sample, pos: POS_BR};
        end else begin
            n_result = r_held_pair;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_br) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_br) begin
            r_out      <= n_result;
            r_out_pend <= r_s1_tag.pend;
            r_out_fend <= r_s1_tag.fend;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pooled_value = $signed(r_out.value);
    assign o_winner_pos   = r_out.pos;
    assign o_plane_end    = r_out_pend;
    assign o_frame_end    = r_out_fend;

endmodule

>>> src/mp2_checker.sv
// port-level checks of the max pooling block and their binding
`include "max_pool_2x2_with_argmax_assert.svh"

module mp2_checker
    import mp2_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic signed [SAMPLE_BITS-1:0] o_pooled_value,
    input logic [1:0]                o_winner_pos,
    input logic                      o_plane_end,
    input logic                      o_frame_end
);

    logic [SAMPLE_BITS+3:0] out_word;

    // everything a result transaction carries
    assign out_word = {o_pooled_value, o_winner_pos, o_plane_end, o_frame_end};

    // a stalled result holds its value and flags
    `MP2_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))

    // the end of a frame is always the end of a plane
    `MP2_ASSERT_SAME(a_frame_in_plane, i_clk, i_rst_n, o_valid && o_frame_end, o_plane_end)

    // input back-pressure only comes from a full, stalled output
    `MP2_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // a fresh result follows a sample transaction through the input register
    `MP2_ASSERT_SAME(a_result_source, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && !o_stall, 2))

endmodule

bind max_pool_2x2_with_argmax mp2_checker u_checker (.*);

>>> dv/max_pool_2x2_with_argmax_checker.sv
// checker for the 2x2 max pooling block: predicts each pooled transaction and compares it
`timescale 1ns / 1ps
module max_pool_2x2_with_argmax_checker
    import mp2_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_sample_valid,
    input  logic                      i_sample_stall,
    input  t_sample                   i_sample_value,
    input  logic                      i_pooled_valid,
    input  logic                      i_pooled_stall,
    input  t_sample                   i_pooled_value,
    input  logic [1:0]                i_winner_pos,
    input  logic                      i_plane_end,
    input  logic                      i_frame_end,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int unsigned MIN_DIM = 2;

    typedef struct packed {
        t_sample    value;
        logic [1:0] pos;
        logic       pend;
        logic       fend;
    } t_pooled;

    // expected pooled transactions, oldest first
    t_pooled pooled_q[$];

    // shadow of the plane geometry registers
    logic [CFG_DIM_BITS-1:0]   width_reg  = WIDTH_RESET;
    logic [CFG_DIM_BITS-1:0]   height_reg = HEIGHT_RESET;
    logic [CFG_PLANE_BITS-1:0] total_reg  = TOTAL_RESET;

    // raster position and window state
    int unsigned col_pos   = 0;
    int unsigned row_pos   = 0;
    int unsigned plane_pos = 0;
    t_sample     left_value = '0;
    t_sample     top_value [PAIR_SLOTS];
    logic        top_col   [PAIR_SLOTS];
    t_sample     run_value = '0;
    logic [1:0]  run_pos   = POS_TL;
    int          fail_count = 0;

    function automatic int unsigned bound(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the window state by one sample, queueing a result on a bottom-right sample
    task automatic pool_sample(input t_sample x);
        int unsigned w, h, n, w_used, h_used, slot;
        logic        right, bottom;
        t_pooled     res;
        w      = bound(width_reg, MIN_DIM, MAX_WIDTH);
        h      = bound(height_reg, MIN_DIM, MAX_HEIGHT);
        n      = bound(total_reg, 1, MAX_PLANES);
        w_used = w - (w % 2);
        h_used = h - (h % 2);
        slot   = col_pos / 2;
        right  = (col_pos % 2) == 1;
        bottom = (row_pos % 2) == 1;
        if (col_pos < w_used && row_pos < h_used) begin
            if (!bottom && !right) begin
                left_value = x;
            end else if (!bottom) begin
                // top pair maximum, left column wins a tie
                if (x > left_value) begin
                    top_value[slot] = x;
                    top_col[slot]   = 1'b1;
                end else begin
                    top_value[slot] = left_value;
                    top_col[slot]   = 1'b0;
                end
            end else if (!right) begin
                if (x > top_value[slot]) begin
                    run_value = x;
                    run_pos   = POS_BL;
                end else begin
                    run_value = top_value[slot];
                    run_pos   = top_col[slot] ? POS_TR : POS_TL;
                end
            end else begin
                res.value = run_value;
                res.pos   = run_pos;
                if (x > run_value) begin
                    res.value = x;
                    res.pos   = POS_BR;
                end
                res.pend = (row_pos == h_used - 1) && (col_pos == w_used - 1);
                res.fend = res.pend && (plane_pos == n - 1);
                pooled_q.push_back(res);
            end
        end
        // counters wrap once they reach or pass their bound
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
                plane_pos++;
                if (plane_pos >= n) plane_pos = 0;
            end
        end
    endtask

    // compare one pooled transaction with the oldest expectation
    task automatic check_pooled();
        t_pooled want;
        if (pooled_q.size() == 0) begin
            $display("%0t: unexpected pooled transaction: value %0d pos %0d pend %0b fend %0b",
                     $time, i_pooled_value, i_winner_pos, i_plane_end, i_frame_end);
            fail_count++;
        end else begin
            want = pooled_q.pop_front();
            if (i_pooled_value !== want.value || i_winner_pos !== want.pos ||
                i_plane_end !== want.pend || i_frame_end !== want.fend) begin
                $display("%0t: expected value %0d pos %0d pend %0b fend %0b", $time,
                         want.value, want.pos, want.pend, want.fend);
                $display("%0t: actual   value %0d pos %0d pend %0b fend %0b", $time,
                         i_pooled_value, i_winner_pos, i_plane_end, i_frame_end);
                fail_count++;
            end
        end
    endtask

    // watch all three channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            total_reg  = TOTAL_RESET;
            col_pos    = 0;
            row_pos    = 0;
            plane_pos  = 0;
            left_value = '0;
            run_value  = '0;
            run_pos    = POS_TL;
            pooled_q.delete();
        end else begin
            if (i_pooled_valid && !i_pooled_stall) check_pooled();
            if (i_sample_valid && !i_sample_stall) pool_sample(i_sample_value);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PLANE_WIDTH:  width_reg  = i_cfg_data[CFG_DIM_BITS-1:0];
                    CFG_PLANE_HEIGHT: height_reg = i_cfg_data[CFG_DIM_BITS-1:0];
                    CFG_PLANE_TOTAL:  total_reg  = i_cfg_data[CFG_PLANE_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= pooled_q.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> dv/max_pool_2x2_with_argmax_test.sv
// testbench top for the 2x2 max pooling block: stimulus, idling and verdict
`timescale 1ns / 1ps
module max_pool_2x2_with_argmax_test;
    import mp2_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 7;

    logic                      clk;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_stall;
    t_sample                   sample_value;
    logic                      pooled_valid;
    logic                      pooled_stall;
    t_sample                   pooled_value;
    logic [1:0]                winner_pos;
    logic                      plane_end;
    logic                      frame_end;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        fail_count;
    int                        pending;

    // sender burst state and raster position of the next sample
    int          burst_left   = 0;
    int unsigned scan_width   = MAX_WIDTH;
    int unsigned scan_height  = MAX_HEIGHT;
    int unsigned scan_col     = 0;
    int unsigned scan_row     = 0;
    bit          hold_request = 1'b0;

    // two planes of 4x3: ties, extremes and every winning position
    t_sample opening_samples [0:23] = '{
        16'sh8000, 16'sh8000, 16'sd1,     16'sh7FFF,
        16'sh8000, 16'sh8000, 16'sd5,     16'sh7FFF,
        16'sh7FFF, 16'sh7FFF, 16'sh8000,  16'sd0,
        -16'sd1,   -16'sd2,   16'sd0,     16'sd0,
        16'sd7,    16'sd7,    -16'sd1,    16'sd1,
        16'sh5555, 16'shAAAA, 16'sd100,   -16'sd100
    };

    max_pool_2x2_with_argmax u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (sample_valid),
        .o_stall        (sample_stall),
        .i_sample_value (sample_value),
        .o_valid        (pooled_valid),
        .i_stall        (pooled_stall),
        .o_pooled_value (pooled_value),
        .o_winner_pos   (winner_pos),
        .o_plane_end    (plane_end),
        .o_frame_end    (frame_end),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    max_pool_2x2_with_argmax_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_sample_valid (sample_valid),
        .i_sample_stall (sample_stall),
        .i_sample_value (sample_value),
        .i_pooled_valid (pooled_valid),
        .i_pooled_stall (pooled_stall),
        .i_pooled_value (pooled_value),
        .i_winner_pos   (winner_pos),
        .i_plane_end    (plane_end),
        .i_frame_end    (frame_end),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    // mostly full-range values, with plenty of ties and extremes
    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            6, 7: return t_sample'(int'($urandom_range(0, 4)) - 2);
            8: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
            default: return t_sample'($urandom);
        endcase
    endfunction

    // one sample transaction, with a random gap ahead of each burst
    task automatic offer_sample(input t_sample v);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(7, 30);
                default:    gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample_value <= v;
        do @(posedge clk); while (sample_stall);
        scan_col++;
        if (scan_col >= scan_width) begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= scan_height) scan_row = 0;
        end
    endtask

    // stop sending, wait for every expected result, then let the pipeline empty
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // geometry may change only at the start of a top row
    task automatic finish_row_pair();
        while (scan_col != 0 || (scan_row % 2) != 0) offer_sample(random_sample());
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(val);
        do @(posedge clk); while (!cfg_ready);
    endtask

    // width and height carry junk above their own bits
    task automatic set_plane(input int unsigned w, input int unsigned h, input int unsigned n);
        write_reg(CFG_PLANE_WIDTH, w | ($urandom_range(0, 63) << CFG_DIM_BITS));
        write_reg(CFG_PLANE_HEIGHT, h | ($urandom_range(0, 63) << CFG_DIM_BITS));
        write_reg(CFG_PLANE_TOTAL, n);
        cfg_valid   <= 1'b0;
        scan_width  = eff_dim(w, MAX_WIDTH);
        scan_height = eff_dim(h, MAX_HEIGHT);
    endtask

    task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned n,
                             input int items);
        set_plane(w, h, n);
        for (int i = 0; i < items; i++) begin
            // now and then the sender waits for the block to run dry
            if ($urandom_range(0, 199) == 0) settle();
            offer_sample(random_sample());
        end
        finish_row_pair();
        settle();
    endtask

    // receiver stall pattern, plus one long hold-off on request
    initial begin
        int mode_left = 0;
        int stall_pct = 0;
        pooled_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                pooled_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(5, 80);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            mode_left--;
            pooled_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog on cycles with no transaction on any channel
    initial begin
        int idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (pooled_valid && !pooled_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("max_pool_2x2_with_argmax: mismatch");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int unsigned w, h, n;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_PLANE_WIDTH;
        cfg_data     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed windows over two small planes, frame end on the second
        set_plane(4, 3, 2);
        foreach (opening_samples[i]) offer_sample(opening_samples[i]);
        finish_row_pair();
        settle();

        // fixed settings: clamped sizes, odd trailing row and column, tallest plane
        run_phase(1, 0, 0, 40);
        run_phase(5, 5, 3, 120);
        run_phase(3, 4, 1, 80);
        run_phase(0, 2047, 131071, 300);
        run_phase(1024, 2, 65536, 0);

        // long receiver hold-off on dense results so the block backs up
        hold_request = 1'b1;
        run_phase(2, 2, 5, 240);

        // random settings, mostly small planes
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0:          w = $urandom_range(0, 1);
                6, 7:       w = $urandom_range(9, 24);
                8:          w = 2 * $urandom_range(1, 7) + 1;
                9:          w = $urandom_range(25, 64);
                default:    w = $urandom_range(2, 8);
            endcase
            h = $urandom_range(0, 7);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(65536, 131071)
                                            : $urandom_range(0, 4);
            run_phase(w, h, n, $urandom_range(80, 160));
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("max_pool_2x2_with_argmax: match");
        else
            $display("max_pool_2x2_with_argmax: mismatch");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/mp2_pkg.sv
src/mp2_scan.sv
src/max_pool_2x2_with_argmax.sv
src/mp2_checker.sv
dv/max_pool_2x2_with_argmax_checker.sv
dv/max_pool_2x2_with_argmax_test.sv
